/* design/tfn_pkg.sv */
`timescale 1ns / 1ps
package tfn_pkg;

   localparam int NEWTON_STEPS = 3;
   localparam int MANT_W = 30;
   localparam int MAG_W = 65;
   localparam int LEN_W = 7;
   localparam int X_W = 26;
   localparam int Y_W = 32;
   localparam int T_W = 34;
   localparam int W_W = 36;
   localparam int Q14_ONE = 16384;

   typedef struct packed {
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] first_z;
      logic signed [31:0] second_x;
      logic signed [31:0] second_y;
      logic signed [31:0] second_z;
      logic signed [31:0] third_x;
      logic signed [31:0] third_y;
      logic signed [31:0] third_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] unit_x;
      logic signed [15:0] unit_y;
      logic signed [15:0] unit_z;
      logic               degenerate;
   } rsp_type;

   typedef struct packed {
      logic [2:0][MANT_W-1:0] mant;
      logic [2:0]             neg;
      logic                   degen;
   } vec_type;

   function automatic logic signed [32:0] sx33(logic signed [31:0] v);
      return {v[31], v};
   endfunction

   function automatic logic [Y_W-1:0] seed(logic [3:0] idx);
      logic [Y_W-1:0] r;
      case (idx)
         4'd0, 4'd1: r = 32'd1753413056;
         4'd2:       r = 32'd1358187914;
         4'd3:       r = 32'd1147878294;
         4'd4:       r = 32'd1012318387;
         4'd5:       r = 32'd915684161;
         4'd6:       r = 32'd842308243;
         4'd7:       r = 32'd784146300;
         4'd8:       r = 32'd736581847;
         4'd9:       r = 32'd696736193;
         4'd10:      r = 32'd662727360;
         default:    r = 32'd633258896;
      endcase
      return r;
   endfunction

endpackage

/* design/tfn_cross.sv */
`timescale 1ns / 1ps
module tfn_cross
   import tfn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  req_type               in_data,
   output logic                  out_valid,
   output logic [2:0][MAG_W-1:0] out_mag,
   output logic [2:0]            out_neg
);

   logic [2:0]                valid_ff, valid_in;
   logic signed [2:0][32:0]   e_ff, e_in, f_ff, f_in;
   logic signed [5:0][65:0]   prod_ff, prod_in;
   logic [2:0][MAG_W-1:0]     mag_ff, mag_in;
   logic [2:0]                neg_ff, neg_in;
   logic signed [66:0]        diff;

   always_comb begin
      e_in[0] = sx33(in_data.second_x) - sx33(in_data.first_x);
      e_in[1] = sx33(in_data.second_y) - sx33(in_data.first_y);
      e_in[2] = sx33(in_data.second_z) - sx33(in_data.first_z);
      f_in[0] = sx33(in_data.third_x) - sx33(in_data.first_x);
      f_in[1] = sx33(in_data.third_y) - sx33(in_data.first_y);
      f_in[2] = sx33(in_data.third_z) - sx33(in_data.first_z);
      prod_in[0] = $signed(e_ff[1]) * $signed(f_ff[2]);
      prod_in[1] = $signed(e_ff[2]) * $signed(f_ff[1]);
      prod_in[2] = $signed(e_ff[2]) * $signed(f_ff[0]);
      prod_in[3] = $signed(e_ff[0]) * $signed(f_ff[2]);
      prod_in[4] = $signed(e_ff[0]) * $signed(f_ff[1]);
      prod_in[5] = $signed(e_ff[1]) * $signed(f_ff[0]);
      diff = '0;
      for (int i = 0; i < 3; i++) begin
         diff = {prod_ff[2*i][65], prod_ff[2*i]} - {prod_ff[2*i+1][65], prod_ff[2*i+1]};
         neg_in[i] = diff[66];
         mag_in[i] = diff[66] ? MAG_W'(-diff) : diff[MAG_W-1:0];
      end
      valid_in = {valid_ff[1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         e_ff    <= e_in;
         f_ff    <= f_in;
         prod_ff <= prod_in;
         mag_ff  <= mag_in;
         neg_ff  <= neg_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_mag   = mag_ff;
   assign out_neg   = neg_ff;

endmodule

/* design/tfn_norm.sv */
`timescale 1ns / 1ps
module tfn_norm
   import tfn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [2:0][MAG_W-1:0] in_mag,
   input  logic [2:0]            in_neg,
   output logic                  out_valid,
   output vec_type               out_vec,
   output logic [X_W-1:0]        out_x,
   output logic [Y_W-1:0]        out_y
);

   logic [3:0]                valid_ff, valid_in;
   logic [MAG_W-1:0]          orv;
   logic [LEN_W-1:0]          len_ff, len_in;
   logic [2:0][MAG_W-1:0]     mag_ff;
   logic [2:0]                neg_ff;
   logic                      degen_ff, degen_in;
   vec_type                   vec5_ff, vec5_in, vec6_ff, vec7_ff;
   logic [2:0][2*MANT_W-1:0]  sq_ff, sq_in;
   logic [2*MANT_W+1:0]       s;
   logic [X_W-1:0]            x_ff;
   logic [Y_W-1:0]            y_ff;

   always_comb begin
      orv = in_mag[0] | in_mag[1] | in_mag[2];
      len_in = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (orv[i]) len_in = LEN_W'(i + 1);
      end
      degen_in = (orv == '0);

      vec5_in.neg = neg_ff;
      vec5_in.degen = degen_ff;
      for (int i = 0; i < 3; i++) begin
         if (len_ff > LEN_W'(MANT_W)) begin
            vec5_in.mant[i] = MANT_W'(mag_ff[i] >> (len_ff - LEN_W'(MANT_W)));
         end else begin
            vec5_in.mant[i] = MANT_W'(mag_ff[i] << (LEN_W'(MANT_W) - len_ff));
         end
         sq_in[i] = vec5_ff.mant[i] * vec5_ff.mant[i];
      end
      s = {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
      valid_in = {valid_ff[2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         mag_ff   <= in_mag;
         neg_ff   <= in_neg;
         len_ff   <= len_in;
         degen_ff <= degen_in;
         vec5_ff  <= vec5_in;
         sq_ff    <= sq_in;
         vec6_ff  <= vec5_ff;
         vec7_ff  <= vec6_ff;
         x_ff     <= s[2*MANT_W+1:36];
         y_ff     <= seed(s[2*MANT_W+1:2*MANT_W-2]);
      end
   end

   assign out_valid = valid_ff[3];
   assign out_vec   = vec7_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;

endmodule

/* design/tfn_newton.sv */
`timescale 1ns / 1ps
module tfn_newton
   import tfn_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  vec_type        in_vec,
   input  logic [X_W-1:0] in_x,
   input  logic [Y_W-1:0] in_y,
   output logic           out_valid,
   output vec_type        out_vec,
   output logic [X_W-1:0] out_x,
   output logic [Y_W-1:0] out_y
);

   localparam logic [W_W-1:0] THREE = W_W'(3) << 30;

   logic [2:0]           valid_ff, valid_in;
   vec_type              vec_a_ff, vec_b_ff, vec_c_ff;
   logic [X_W-1:0]       x_a_ff, x_b_ff, x_c_ff;
   logic [Y_W-1:0]       y_a_ff, y_b_ff, y_c_ff;
   logic [2*Y_W-1:0]     yy;
   logic [T_W-1:0]       t_ff;
   logic [X_W+T_W-1:0]   xt;
   logic [W_W-1:0]       w_ff;
   logic [Y_W-1:0]       d;
   logic [2*Y_W-1:0]     yd;

   always_comb begin
      yy = in_y * in_y;
      xt = x_a_ff * t_ff;
      d  = (w_ff < THREE) ? Y_W'(THREE - w_ff) : '0;
      yd = y_b_ff * d;
      valid_in = {valid_ff[1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         vec_a_ff <= in_vec;
         x_a_ff   <= in_x;
         y_a_ff   <= in_y;
         t_ff     <= yy[2*Y_W-1:30];
         vec_b_ff <= vec_a_ff;
         x_b_ff   <= x_a_ff;
         y_b_ff   <= y_a_ff;
         w_ff     <= xt[X_W+T_W-1:24];
         vec_c_ff <= vec_b_ff;
         x_c_ff   <= x_b_ff;
         y_c_ff   <= yd[Y_W+30:31];
      end
   end

   assign out_valid = valid_ff[2];
   assign out_vec   = vec_c_ff;
   assign out_x     = x_c_ff;
   assign out_y     = y_c_ff;

endmodule

/* design/tfn_scale.sv */
`timescale 1ns / 1ps
module tfn_scale
   import tfn_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  vec_type        in_vec,
   input  logic [Y_W-1:0] in_y,
   output logic           out_valid,
   output rsp_type        out_data
);

   localparam int P_W = MANT_W + Y_W;

   logic [1:0]           valid_ff, valid_in;
   logic [2:0][P_W-1:0]  prod_ff, prod_in;
   logic [2:0]           neg_ff;
   logic                 degen_ff;
   logic [2:0][15:0]     q_in;
   logic [P_W-1:0]       rnd;
   logic [P_W-47:0]      n;
   rsp_type              rsp_ff, rsp_in;

   always_comb begin
      rnd = '0;
      n = '0;
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = in_vec.mant[i] * in_y;
         rnd = prod_ff[i] + (P_W'(1) << 45);
         n = rnd[P_W-1:46];
         if (n > (P_W-46)'(Q14_ONE)) n = (P_W-46)'(Q14_ONE);
         q_in[i] = neg_ff[i] ? 16'(-n) : 16'(n);
         if (degen_ff) q_in[i] = '0;
      end
      rsp_in.unit_x     = q_in[0];
      rsp_in.unit_y     = q_in[1];
      rsp_in.unit_z     = q_in[2];
      rsp_in.degenerate = degen_ff;
      valid_in = {valid_ff[0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         prod_ff  <= prod_in;
         neg_ff   <= in_vec.neg;
         degen_ff <= in_vec.degen;
         rsp_ff   <= rsp_in;
      end
   end

   assign out_valid = valid_ff[1];
   assign out_data  = rsp_ff;

endmodule

/* design/triangle_face_normal.sv */
`timescale 1ns / 1ps
// channel   direction  handshake        payload
// req       in         valid / stall    req_type, three vertices in Q16.16
// rsp       out        valid / stall    rsp_type, unit normal in Q1.14 and flag
//
// one triangle per cycle while no stalled result holds the pipeline
// each refinement step costs three multiplier stages in series
// synchronous active-high reset clears only the valid bits
// a stalled result freezes the whole pipeline and raises req_stall
module triangle_face_normal
   import tfn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic                  en;
   logic                  cross_valid;
   logic [2:0][MAG_W-1:0] cross_mag;
   logic [2:0]            cross_neg;

   logic                  nv   [NEWTON_STEPS+1];
   vec_type               nvec [NEWTON_STEPS+1];
   logic [X_W-1:0]        nx   [NEWTON_STEPS+1];
   logic [Y_W-1:0]        ny   [NEWTON_STEPS+1];

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   tfn_cross u_cross (
      .clock, .reset, .en,
      .in_valid (req_valid),
      .in_data  (req_data),
      .out_valid(cross_valid),
      .out_mag  (cross_mag),
      .out_neg  (cross_neg)
   );

   tfn_norm u_norm (
      .clock, .reset, .en,
      .in_valid (cross_valid),
      .in_mag   (cross_mag),
      .in_neg   (cross_neg),
      .out_valid(nv[0]),
      .out_vec  (nvec[0]),
      .out_x    (nx[0]),
      .out_y    (ny[0])
   );

   for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
      tfn_newton u_newton (
         .clock, .reset, .en,
         .in_valid (nv[k]),
         .in_vec   (nvec[k]),
         .in_x     (nx[k]),
         .in_y     (ny[k]),
         .out_valid(nv[k+1]),
         .out_vec  (nvec[k+1]),
         .out_x    (nx[k+1]),
         .out_y    (ny[k+1])
      );
   end

   tfn_scale u_scale (
      .clock, .reset, .en,
      .in_valid (nv[NEWTON_STEPS]),
      .in_vec   (nvec[NEWTON_STEPS]),
      .in_y     (ny[NEWTON_STEPS]),
      .out_valid(rsp_valid),
      .out_data (rsp_data)
   );

endmodule

/* design/tfn_checker.sv */
`timescale 1ns / 1ps
module tfn_checker
   import tfn_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("request changed while stalled");

   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output stall");

   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.unit_x == 16'sd0 && rsp_data.unit_y == 16'sd0 &&
         rsp_data.unit_z == 16'sd0)
      else $error("degenerate transaction with nonzero normal");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_data.unit_x <= 16'sd16384 && rsp_data.unit_x >= -16'sd16384 &&
         rsp_data.unit_y <= 16'sd16384 && rsp_data.unit_y >= -16'sd16384 &&
         rsp_data.unit_z <= 16'sd16384 && rsp_data.unit_z >= -16'sd16384)
      else $error("normal component out of range");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (.*);

/* verif/triangle_face_normal_test.sv */
`timescale 1ns / 1ps
module triangle_face_normal_test;
   import tfn_pkg::*;

   localparam int LATENCY = 9 + 3 * NEWTON_STEPS;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type normal_queue[$];
   int      error_count;
   int      send_idle_pct;
   int      recv_idle_pct;
   int      hold_off_cycles;

   triangle_face_normal dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("[triangle_face_normal] ERROR");
      $finish;
   end

   function automatic logic [63:0] seed_value(int idx);
      case (idx)
         0, 1: return 64'd1753413056;
         2: return 64'd1358187914;
         3: return 64'd1147878294;
         4: return 64'd1012318387;
         5: return 64'd915684161;
         6: return 64'd842308243;
         7: return 64'd784146300;
         8: return 64'd736581847;
         9: return 64'd696736193;
         10: return 64'd662727360;
         default: return 64'd633258896;
      endcase
   endfunction

   function automatic rsp_type face_normal(req_type t);
      logic signed [33:0] ex, ey, ez, fx, fy, fz;
      logic signed [67:0] c[3];
      logic [66:0] mag[3];
      logic [66:0] all_bits;
      logic [63:0] m[3];
      logic [63:0] s, x, y, tt, w, d, n;
      logic [127:0] prod;
      int len, k;
      rsp_type r;
      ex = 34'(t.second_x) - 34'(t.first_x);
      ey = 34'(t.second_y) - 34'(t.first_y);
      ez = 34'(t.second_z) - 34'(t.first_z);
      fx = 34'(t.third_x) - 34'(t.first_x);
      fy = 34'(t.third_y) - 34'(t.first_y);
      fz = 34'(t.third_z) - 34'(t.first_z);
      c[0] = 68'(ey) * 68'(fz) - 68'(ez) * 68'(fy);
      c[1] = 68'(ez) * 68'(fx) - 68'(ex) * 68'(fz);
      c[2] = 68'(ex) * 68'(fy) - 68'(ey) * 68'(fx);
      for (int i = 0; i < 3; i++) mag[i] = 67'(c[i] < 0 ? -c[i] : c[i]);
      all_bits = mag[0] | mag[1] | mag[2];
      len = 0;
      for (int b = 0; b < 67; b++) if (all_bits[b]) len = b + 1;
      r = '0;
      if (len == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      for (int i = 0; i < 3; i++)
         m[i] = len > 30 ? 64'(mag[i] >> (len - 30)) : 64'(mag[i] << (30 - len));
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      x = s >> 36;
      y = seed_value(int'((s >> 58) & 64'd15));
      for (k = 0; k < NEWTON_STEPS; k++) begin
         tt = (y * y) >> 30;
         w = (x * tt) >> 24;
         d = w < (64'd3 << 30) ? (64'd3 << 30) - w : 64'd0;
         y = (y * d) >> 31;
      end
      for (int i = 0; i < 3; i++) begin
         prod = (128'(m[i]) * 128'(y) + (128'd1 << 45)) >> 46;
         n = prod > 128'(Q14_ONE) ? 64'(Q14_ONE) : 64'(prod);
         if (c[i] < 0) n = -n;
         case (i)
            0: r.unit_x = n[15:0];
            1: r.unit_y = n[15:0];
            default: r.unit_z = n[15:0];
         endcase
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
      error_count++;
   endtask

   task automatic send_triangle(req_type t);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      normal_queue.push_back(face_normal(t));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (normal_queue.size() == 0) begin
            $display("mismatch: transaction with no expectation");
            error_count++;
         end else begin
            rsp_type e;
            e = normal_queue.pop_front();
            if (rsp_data.unit_x !== e.unit_x)
               report_mismatch("unit_x", rsp_data.unit_x, e.unit_x);
            if (rsp_data.unit_y !== e.unit_y)
               report_mismatch("unit_y", rsp_data.unit_y, e.unit_y);
            if (rsp_data.unit_z !== e.unit_z)
               report_mismatch("unit_z", rsp_data.unit_z, e.unit_z);
            if (rsp_data.degenerate !== e.degenerate)
               report_mismatch("degenerate", 16'(rsp_data.degenerate), 16'(e.degenerate));
         end
      end
   end

   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct;
      end
   end

   function automatic logic [31:0] random_coord();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
         2: return 32'($signed($urandom_range(64)) - 32);
         3: return {$urandom_range(1) ? 2'b01 : 2'b10, 30'($urandom)};
         4: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         default: return 32'($signed($urandom_range(200000)) - 100000);
      endcase
   endfunction

   function automatic req_type random_triangle();
      req_type t;
      t.first_x = random_coord(); t.first_y = random_coord(); t.first_z = random_coord();
      t.second_x = random_coord(); t.second_y = random_coord(); t.second_z = random_coord();
      t.third_x = random_coord(); t.third_y = random_coord(); t.third_z = random_coord();
      if ($urandom_range(15) == 0) begin
         t.second_x = t.first_x; t.second_y = t.first_y; t.second_z = t.first_z;
      end else if ($urandom_range(15) == 0) begin
         t.third_x = t.second_x; t.third_y = t.second_y; t.third_z = t.second_z;
      end
      return t;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (normal_queue.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      req_type t;
      logic [31:0] ext[4];
      ext = '{32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff};
      t = '0;
      send_triangle(t);
      t = '0; t.second_x = 32'h10000; t.third_y = 32'h10000;
      send_triangle(t);
      t = '0; t.second_y = 32'h10000; t.third_z = 32'h10000;
      send_triangle(t);
      t = '0; t.second_z = 32'h10000; t.third_x = 32'h10000;
      send_triangle(t);
      t = '0; t.second_x = 32'h10000; t.third_x = 32'h20000;
      send_triangle(t);
      t = '0; t.second_x = 1; t.third_y = 1;
      send_triangle(t);
      t = '0; t.second_x = 32'h10000; t.second_y = 32'h10000; t.third_x = 32'h10000;
      t.third_z = 32'h10000;
      send_triangle(t);
      for (int i = 0; i < 4; i++) begin
         t = {9{ext[i]}};
         send_triangle(t);
         t.second_x = ext[(i + 1) % 4]; t.third_y = ext[(i + 1) % 4];
         t.third_z = ext[(i + 2) % 4];
         send_triangle(t);
      end
      t.first_x = 32'h80000000; t.first_y = 32'h7fffffff; t.first_z = 32'h80000000;
      t.second_x = 32'h7fffffff; t.second_y = 32'h80000000; t.second_z = 32'h80000000;
      t.third_x = 32'h80000000; t.third_y = 32'h80000000; t.third_z = 32'h7fffffff;
      send_triangle(t);
      t = '0; t.second_x = 32'h10000; t.second_y = 32'h10000; t.third_x = 32'hffff0000;
      t.third_y = 32'h10000;
      send_triangle(t);
      t = '0; t.second_x = 3; t.second_y = 4; t.third_z = 1;
      send_triangle(t);
      wait_drained();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) send_triangle(random_triangle());
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_off_cycles <= 200;
      for (int i = 0; i < 60; i++) send_triangle(random_triangle());
      wait_drained();
      repeat (20) send_triangle(random_triangle());
      wait_drained();
   endtask

   initial begin
      error_count = 0;
      send_idle_pct = 10;
      recv_idle_pct = 81;
      hold_off_cycles = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_stall <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(650);
      send_idle_pct = 81;
      recv_idle_pct = 10;
      test_random(650);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(650);
      test_backpressure();
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && normal_queue.size() == 0)
         $display("[triangle_face_normal] OK");
      else
         $display("[triangle_face_normal] ERROR");
      $finish;
   end

endmodule
